@@ hw/rtl/fled_pkg.sv @@
// ----------------------------------------------------------------------------
// Flicker LED dimmer package
// Shared widths, event and register codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package fled_pkg;

  localparam int OP_W      = 2;
  localparam int LEVEL_W   = 8;
  localparam int COUNT_W   = 16;
  localparam int RNG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [OP_W-1:0] OP_PWM    = 2'd0;
  localparam logic [OP_W-1:0] OP_RAMP   = 2'd1;
  localparam logic [OP_W-1:0] OP_BUTTON = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME = 1'd1;

  localparam logic [RNG_W-1:0]   LCG_MUL     = 32'd1103515245;
  localparam logic [RNG_W-1:0]   LCG_ADD     = 32'd12345;
  localparam logic [LEVEL_W-1:0] EDGE_OFFSET = 8'd30;
  localparam logic [15:0]        EDGE_LOW_K  = 16'd50;
  localparam logic [15:0]        EDGE_HIGH_K = 16'd226;
  localparam logic [COUNT_W-1:0] FRAME_RESET = 16'd2930;
  localparam logic [LEVEL_W-1:0] DUTY_RESET  = 8'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // apply the accepted event
    logic mul;       // generator product step
    logic add;       // generator add step, loads the remainder unit
    logic div;       // one remainder bit step
    logic store;     // write the drawn duty
    logic sel_two;   // which duty the store writes
    logic lower;     // end-of-frame brightness fall
    logic load_out;  // load the result word
  } fled_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic div_last;
  } fled_sts_t;

endpackage

@@ hw/rtl/fled_if.sv @@
// ----------------------------------------------------------------------------
// Flicker LED dimmer channels
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface fled_in_if import fled_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic            button_level;

  modport source (output valid, output opcode, output button_level, input ready);
  modport sink (input valid, input opcode, input button_level, output ready);
endinterface

interface fled_out_if import fled_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               led_one;
  logic               led_two;
  logic [LEVEL_W-1:0] brightness_now;

  modport source (output valid, output led_one, output led_two, output brightness_now,
                  input ready);
  modport sink (input valid, input led_one, input led_two, input brightness_now,
                output ready);
endinterface

@@ hw/rtl/fled_dp.sv @@
// ----------------------------------------------------------------------------
// Flicker LED dimmer datapath
// PWM phase, frame counter, brightness, random generator, serial remainder
// unit and the result word register.
// ----------------------------------------------------------------------------
module fled_dp import fled_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fled_cmd_t            cmd,
  output fled_sts_t            sts,
  input  logic [OP_W-1:0]      opcode,
  input  logic                 button_level,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 led_one,
  output logic                 led_two,
  output logic [LEVEL_W-1:0]   brightness_now
);

  logic [LEVEL_W-1:0] pwm_phase_r, duty_one_r, duty_two_r, brightness_r;
  logic [COUNT_W-1:0] frame_count_r, frame_length_r;
  logic               held_r, drive_a_r, drive_b_r;
  logic [RNG_W-1:0]   rng_state_r, prod_r;

  logic [LEVEL_W-1:0] edge_low_r, span_r, rem_r, dividend_r;
  logic               span_ok_r;
  logic [2:0]         bit_cnt_r;

  logic               led_one_r, led_two_r;
  logic [LEVEL_W-1:0] bright_out_r;

  logic [LEVEL_W-1:0] phase_nxt;
  logic [COUNT_W:0]   count_inc;
  logic               frame_end;
  logic [15:0]        low_prod, high_prod;
  logic [LEVEL_W-1:0] edge_low_nxt, edge_high_nxt;
  logic [RNG_W-1:0]   rng_nxt;
  logic [LEVEL_W:0]   trial;
  logic [LEVEL_W-1:0] duty_drawn;

  assign phase_nxt = pwm_phase_r + 8'd1;
  assign count_inc = {1'b0, frame_count_r} + 17'd1;
  // The widened compare also ends a frame when the count has wrapped past 16 bits.
  assign frame_end = (opcode == OP_PWM) && (count_inc >= {1'b0, frame_length_r});

  assign low_prod      = {8'd0, brightness_r} * EDGE_LOW_K;
  assign high_prod     = {8'd0, brightness_r} * EDGE_HIGH_K;
  assign edge_low_nxt  = low_prod[15:8];
  assign edge_high_nxt = high_prod[15:8] + EDGE_OFFSET;

  assign rng_nxt    = prod_r + LCG_ADD;
  assign trial      = {rem_r, dividend_r[LEVEL_W-1]};
  assign duty_drawn = span_ok_r ? (edge_low_r + rem_r) : edge_low_r;

  assign sts.frame_end = frame_end;
  assign sts.div_last  = (bit_cnt_r == 3'd7);

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_phase_r    <= '0;
      duty_one_r     <= DUTY_RESET;
      duty_two_r     <= DUTY_RESET;
      frame_count_r  <= '0;
      frame_length_r <= FRAME_RESET;
      brightness_r   <= '0;
      held_r         <= 1'b0;
      drive_a_r      <= 1'b0;
      drive_b_r      <= 1'b0;
      rng_state_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED:  rng_state_r    <= cfg_data[RNG_W-1:0];
          CFG_FRAME: frame_length_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (opcode)
          OP_PWM: begin
            pwm_phase_r   <= phase_nxt;
            drive_a_r     <= (duty_one_r > phase_nxt);
            drive_b_r     <= (duty_two_r > phase_nxt);
            frame_count_r <= frame_end ? '0 : count_inc[COUNT_W-1:0];
          end
          OP_RAMP: begin
            if (held_r && brightness_r != LEVEL_MAX) begin
              brightness_r <= brightness_r + 8'd1;
            end
          end
          OP_BUTTON: begin
            held_r <= button_level;
            if (button_level && brightness_r != LEVEL_MAX) begin
              brightness_r <= brightness_r + 8'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.add) begin
        rng_state_r <= rng_nxt;
      end
      if (cmd.store) begin
        if (cmd.sel_two) begin
          duty_two_r <= duty_drawn;
        end else begin
          duty_one_r <= duty_drawn;
        end
      end
      if (cmd.lower && !held_r && brightness_r != '0) begin
        brightness_r <= brightness_r - 8'd1;
      end
    end
  end

  // Draw datapath: edges captured at the frame event, generator, remainder unit.
  always_ff @(posedge clk) begin
    if (cmd.accept && frame_end) begin
      edge_low_r <= edge_low_nxt;
      span_r     <= edge_high_nxt - edge_low_nxt;
      span_ok_r  <= (edge_high_nxt > edge_low_nxt) && (edge_high_nxt != edge_low_nxt);
    end
    if (cmd.mul) begin
      prod_r <= rng_state_r * LCG_MUL;
    end
    if (cmd.add) begin
      dividend_r <= rng_nxt[23:16];
      rem_r      <= '0;
      bit_cnt_r  <= '0;
    end
    if (cmd.div) begin
      // Restoring remainder, one dividend bit per cycle, MSB first.
      if (trial >= {1'b0, span_r}) begin
        rem_r <= LEVEL_W'(trial - {1'b0, span_r});
      end else begin
        rem_r <= trial[LEVEL_W-1:0];
      end
      dividend_r <= {dividend_r[LEVEL_W-2:0], 1'b0};
      bit_cnt_r  <= bit_cnt_r + 3'd1;
    end
    if (cmd.load_out) begin
      led_one_r    <= drive_a_r;
      led_two_r    <= drive_b_r;
      bright_out_r <= brightness_r;
    end
  end

  assign led_one        = led_one_r;
  assign led_two        = led_two_r;
  assign brightness_now = bright_out_r;

endmodule

@@ hw/rtl/fled_ctrl.sv @@
// ----------------------------------------------------------------------------
// Flicker LED dimmer controller
// Sequences one event word at a time through the datapath and owns the
// result word handshake.
// ----------------------------------------------------------------------------
module fled_ctrl import fled_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fled_sts_t sts,
  output fled_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_LOWER = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       second_r, second_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.sel_two = second_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd.accept = 1'b1;
          second_nxt = 1'b0;
          state_nxt  = sts.frame_end ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (second_r) begin
          state_nxt = S_LOWER;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_LOWER: begin
        cmd.lower = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A pending word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result word overwritten while pending");

  // A frame-ending tick starts the generator.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && sts.frame_end) |=> (state_r == S_MUL))
    else $error("frame event did not start a draw");

  // The add step always hands over to the remainder unit.
  a_add_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> (state_r == S_DIV))
    else $error("remainder unit not started after generator step");

  // The second draw's store leads to the brightness fall.
  a_second_lower: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE && second_r) |=> (state_r == S_LOWER))
    else $error("frame did not end with the brightness step");

endmodule

@@ hw/rtl/flicker_led_pwm_dimmer.sv @@
// ----------------------------------------------------------------------------
// Flicker LED PWM dimmer, top level
// Two-channel flame-flicker LED driver with button-controlled brightness.
// ----------------------------------------------------------------------------
// Each event word produces exactly one result word. Ramp ticks, button changes
// and PWM ticks that do not end a frame go from acceptance straight to the
// result word; a PWM tick that ends a frame first draws both new duties one
// after the other, each through a two-step generator update and a remainder
// unit that takes one bit per cycle. One event word is in work at a time; the
// next is taken once the current result is registered, even if that result
// has not yet been taken. No clearing pass after reset.
module flicker_led_pwm_dimmer import fled_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fled_in_if.sink              in_word,
  fled_out_if.source           out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  fled_cmd_t cmd;
  fled_sts_t sts;

  fled_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fled_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (in_word.opcode),
    .button_level   (in_word.button_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .led_one        (out_word.led_one),
    .led_two        (out_word.led_two),
    .brightness_now (out_word.brightness_now)
  );

endmodule
